// File: hw/rtl/sdic_pkg.sv
// Shared types, constants and segment tables for the display image composer.
`timescale 1ns / 1ps

package sdic_pkg;

   localparam int unsigned DISPLAY_BYTES = 11;
   localparam int unsigned DIGITS        = 4;

   localparam logic [7:0] SEG_DP = 8'h80;
   localparam logic [7:0] SEG_G  = 8'h20;

   // number conditioning limits
   localparam int unsigned NEG_LIMIT      = 1999;
   localparam int unsigned NEG_CLAMP      = 200;
   localparam int unsigned PLAIN_MAX      = 999;
   localparam int unsigned FOUR_DIGIT_MAX = 9999;
   localparam int unsigned ROUND_HUNDREDS = 50;
   localparam int unsigned ROUND_TENS     = 5;

   // reciprocals for constant division (exact over the value ranges used)
   localparam int unsigned RECIP_10      = 52429;   // 17-bit dividend, shift 19
   localparam int unsigned SHIFT_10      = 19;
   localparam int unsigned RECIP_100     = 83887;   // 17-bit dividend, shift 23
   localparam int unsigned SHIFT_100     = 23;
   localparam int unsigned RECIP_1000    = 33555;   // value up to 9999, shift 25
   localparam int unsigned SHIFT_1000    = 25;
   localparam int unsigned RECIP_MOD10   = 13108;   // value up to 9999, shift 17
   localparam int unsigned SHIFT_MOD10   = 17;

   // indicator nibble masks
   localparam logic [7:0] IND_KEEP0 = 8'hF9;
   localparam logic [7:0] IND_KEEP1 = 8'hF8;
   localparam logic [7:0] IND_KEEP2 = 8'h8F;

   typedef enum logic [1:0] {
      MODE_NUMBER    = 2'd0,
      MODE_CHARS     = 2'd1,
      MODE_INDICATOR = 2'd2,
      MODE_UNIT      = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      UNIT_NONE        = 2'd0,
      UNIT_HUMIDITY    = 2'd1,
      UNIT_TEMPERATURE = 2'd2,
      UNIT_KEEP        = 2'd3
   } unit_kind_type;

   typedef struct packed {
      logic [1:0]         mode;
      logic               window;
      logic signed [15:0] value;
      logic [1:0]         dot_pos;
      logic [7:0]         char0;
      logic [7:0]         char1;
      logic [7:0]         char2;
      logic [7:0]         char3;
      logic [7:0]         indicator_bits;
      logic [1:0]         unit_kind;
   } req_type;

   typedef struct packed {
      logic [63:0] image_low;
      logic [23:0] image_high;
   } rsp_type;

   // command fields that ride along the pipeline
   typedef struct packed {
      mode_type      mode;
      logic          window;
      logic [1:0]    dot_pos;
      logic          neg;
      logic          big;
      logic [7:0]    indicator_bits;
      unit_kind_type unit_kind;
   } cmd_type;

   typedef struct packed {
      cmd_type               cmd;
      logic [13:0]           value;
      logic [3:0][7:0]       chars;   // chars[0] is the leftmost digit
   } front_type;

   typedef struct packed {
      logic [3:0] digit;
      logic [7:0] char_pat;
   } lane_out_type;

   localparam logic [7:0] LETTER_PAT [26] = '{
      8'h77, 8'h6E, 8'h2C, 8'h7C, 8'h2F, 8'h27, 8'h7B, 8'h76, 8'h50, 8'h58, 8'h66, 8'h0E,
      8'h65, 8'h64, 8'h6C, 8'h37, 8'h73, 8'h24, 8'h6B, 8'h2E, 8'h5E, 8'h4C, 8'h1A, 8'h76,
      8'h7A, 8'h3D
   };

   function automatic logic [7:0] digit_pattern(input logic [3:0] d);
      logic [7:0] pat;
      case (d)
         4'd0:    pat = 8'h5F;
         4'd1:    pat = 8'h50;
         4'd2:    pat = 8'h3D;
         4'd3:    pat = 8'h79;
         4'd4:    pat = 8'h72;
         4'd5:    pat = 8'h6B;
         4'd6:    pat = 8'h6F;
         4'd7:    pat = 8'h51;
         4'd8:    pat = 8'h7F;
         4'd9:    pat = 8'h7B;
         default: pat = 8'h00;
      endcase
      return pat;
   endfunction

   function automatic logic [7:0] char_pattern(input logic [7:0] c);
      logic [7:0] pat;
      case (c) inside
         [8'h30:8'h39]: pat = digit_pattern(4'(c - 8'h30));
         [8'h41:8'h5A]: pat = LETTER_PAT[5'(c - 8'h41)];
         8'h2D:         pat = SEG_G;
         default:       pat = 8'h00;
      endcase
      return pat;
   endfunction

   // value / 10**place for a conditioned value (at most 9999)
   function automatic logic [13:0] scaled_value(input logic [13:0] v, input logic [1:0] place);
      logic [31:0] prod;
      logic [13:0] q;
      case (place)
         2'd0: begin
            prod = 32'(v);
            q    = v;
         end
         2'd1: begin
            prod = 32'(v) * 32'(RECIP_10);
            q    = 14'(prod >> SHIFT_10);
         end
         2'd2: begin
            prod = 32'(v) * 32'(RECIP_100);
            q    = 14'(prod >> SHIFT_100);
         end
         default: begin
            prod = 32'(v) * 32'(RECIP_1000);
            q    = 14'(prod >> SHIFT_1000);
         end
      endcase
      return q;
   endfunction

endpackage

// File: hw/rtl/sdic_front.sv
// Input stage: sign handling, clamping and rounding of the number, first pipeline register.
`timescale 1ns / 1ps

module sdic_front (
   input  logic                clock,
   input  logic                load,
   input  sdic_pkg::req_type   req_data,
   output sdic_pkg::front_type s1_data
);

   logic        neg;
   logic [16:0] ext;
   logic [16:0] mag;
   logic [1:0]  dot;
   logic        neg_flag;
   logic        big;
   logic [16:0] sum100;
   logic [16:0] sum10;
   logic [33:0] prod100;
   logic [33:0] prod10;
   logic [13:0] q100;
   logic [13:0] q10;
   logic [13:0] value_norm;
   sdic_pkg::front_type s1_in;
   sdic_pkg::front_type s1_ff;

   always_comb begin
      neg      = req_data.value[15];
      ext      = {req_data.value[15], req_data.value};
      mag      = neg ? (17'd0 - ext) : ext;
      dot      = req_data.dot_pos;
      neg_flag = 1'b0;
      if (neg) begin
         if (req_data.window == 1'b0) begin
            mag = '0;
         end else begin
            if (mag > 17'(sdic_pkg::NEG_LIMIT)) begin
               mag = 17'(sdic_pkg::NEG_CLAMP);
               dot = '0;
            end
            neg_flag = 1'b1;
         end
      end
      big     = mag > 17'(sdic_pkg::PLAIN_MAX);
      sum100  = mag + 17'(sdic_pkg::ROUND_HUNDREDS);
      sum10   = mag + 17'(sdic_pkg::ROUND_TENS);
      prod100 = 34'(sum100) * 34'(sdic_pkg::RECIP_100);
      prod10  = 34'(sum10) * 34'(sdic_pkg::RECIP_10);
      q100    = 14'(prod100 >> sdic_pkg::SHIFT_100);
      q10     = 14'(prod10 >> sdic_pkg::SHIFT_10);

      value_norm = 14'(mag);
      if (big) begin
         if (req_data.window == 1'b0) begin
            value_norm = (mag > 17'(sdic_pkg::FOUR_DIGIT_MAX)) ? q100 : q10;
            dot        = '0;
         end else if (mag > 17'(sdic_pkg::FOUR_DIGIT_MAX)) begin
            value_norm = q10;
            dot        = '0;
         end
      end

      s1_in.cmd.mode           = sdic_pkg::mode_type'(req_data.mode);
      s1_in.cmd.window         = req_data.window;
      // the number path may drop the point; characters keep it as given
      s1_in.cmd.dot_pos        = (s1_in.cmd.mode == sdic_pkg::MODE_NUMBER) ? dot
                                                                          : req_data.dot_pos;
      s1_in.cmd.neg            = neg_flag;
      s1_in.cmd.big            = big;
      s1_in.cmd.indicator_bits = req_data.indicator_bits;
      s1_in.cmd.unit_kind      = sdic_pkg::unit_kind_type'(req_data.unit_kind);
      s1_in.value              = value_norm;
      s1_in.chars[0]           = req_data.char0;
      s1_in.chars[1]           = req_data.char1;
      s1_in.chars[2]           = req_data.char2;
      s1_in.chars[3]           = req_data.char3;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         s1_ff <= s1_in;
      end
   end

   assign s1_data = s1_ff;

endmodule

// File: hw/rtl/sdic_lane.sv
// One digit lane: scaled value and character in, decimal digit and character pattern out.
`timescale 1ns / 1ps

module sdic_lane (
   input  logic                   clock,
   input  logic                   load_scale,
   input  logic                   load_digit,
   input  logic [13:0]            scaled,
   input  logic [7:0]             char_code,
   output sdic_pkg::lane_out_type lane_out
);

   logic [13:0] scaled_ff;
   logic [7:0]  char_ff;
   logic [31:0] prod;
   logic [9:0]  tens;
   logic [13:0] tens_x10;
   sdic_pkg::lane_out_type lane_in;
   sdic_pkg::lane_out_type lane_ff;

   always_ff @(posedge clock) begin
      if (load_scale) begin
         scaled_ff <= scaled;
         char_ff   <= char_code;
      end
   end

   // digit = scaled mod 10
   always_comb begin
      prod             = 32'(scaled_ff) * 32'(sdic_pkg::RECIP_MOD10);
      tens             = 10'(prod >> sdic_pkg::SHIFT_MOD10);
      tens_x10         = 14'({tens, 3'b000}) + 14'({tens, 1'b0});
      lane_in.digit    = 4'(scaled_ff - tens_x10);
      lane_in.char_pat = sdic_pkg::char_pattern(char_ff);
   end

   always_ff @(posedge clock) begin
      if (load_digit) begin
         lane_ff <= lane_in;
      end
   end

   assign lane_out = lane_ff;

endmodule

// File: hw/rtl/sdic_merge.sv
// Merge stage: blanking across lanes, nibble placement and the display image register.
`timescale 1ns / 1ps

module sdic_merge (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        load,
   input  sdic_pkg::cmd_type           cmd,
   input  sdic_pkg::lane_out_type [3:0] lane_out,
   output sdic_pkg::rsp_type           rsp_data
);

   logic [sdic_pkg::DISPLAY_BYTES-1:0][7:0] image_ff;
   logic [sdic_pkg::DISPLAY_BYTES-1:0][7:0] image_in;
   sdic_pkg::rsp_type                       rsp_data_ff;
   logic [3:0][7:0]                         pat;
   logic                                    seen;
   logic [3:0]                              pos;
   logic [3:0]                              ma_byte;
   logic [7:0]                              ma;
   logic [3:0]                              mb_byte;

   always_comb begin
      image_in = image_ff;
      seen     = 1'b0;
      pos      = '0;
      ma_byte  = cmd.window ? 4'd1 : 4'd2;
      ma       = cmd.window ? 8'h08 : 8'h80;
      mb_byte  = cmd.window ? 4'd6 : 4'd2;

      for (int i = 0; i < sdic_pkg::DIGITS; i++) begin
         if (cmd.mode == sdic_pkg::MODE_NUMBER) begin
            pat[i] = sdic_pkg::digit_pattern(lane_out[i].digit);
            // negative with the point at the far left: a leading zero goes dark
            if (cmd.neg && lane_out[i].digit == 4'd0 && cmd.dot_pos == 2'd3 && i == 0) begin
               pat[i] = '0;
               seen   = 1'b1;
            end
            if (lane_out[i].digit != 4'd0) begin
               seen = 1'b1;
            end
            if (!seen && (i + int'(cmd.dot_pos)) < 3 && !cmd.big) begin
               pat[i] = '0;
            end
            if (i == 0 && cmd.neg) begin
               pat[i] = pat[i] | sdic_pkg::SEG_G;
            end
         end else begin
            pat[i] = lane_out[i].char_pat;
         end
         if (cmd.dot_pos != 2'd0 && (i + int'(cmd.dot_pos)) == 3) begin
            pat[i] = pat[i] | sdic_pkg::SEG_DP;
         end
      end

      case (cmd.mode)
         sdic_pkg::MODE_NUMBER, sdic_pkg::MODE_CHARS: begin
            for (int i = 0; i < sdic_pkg::DIGITS; i++) begin
               pos = 4'(10 - i - (cmd.window ? 4 : 0));
               image_in[pos][7:4]       = pat[i][3:0];
               image_in[pos - 4'd1][3:0] = pat[i][7:4];
            end
         end
         sdic_pkg::MODE_INDICATOR: begin
            image_in[0] = (image_ff[0] & sdic_pkg::IND_KEEP0)
                        | {5'b0, cmd.indicator_bits[7:6], 1'b0};
            image_in[1] = (image_ff[1] & sdic_pkg::IND_KEEP1)
                        | {5'b0, cmd.indicator_bits[5:3]};
            image_in[2] = (image_ff[2] & sdic_pkg::IND_KEEP2)
                        | {1'b0, cmd.indicator_bits[2:0], 4'b0};
         end
         sdic_pkg::MODE_UNIT: begin
            case (cmd.unit_kind)
               sdic_pkg::UNIT_NONE: begin
                  image_in[ma_byte] = image_in[ma_byte] & ~ma;
                  image_in[mb_byte] = image_in[mb_byte] & 8'hF7;
               end
               sdic_pkg::UNIT_HUMIDITY: begin
                  image_in[ma_byte] = image_in[ma_byte] | ma;
                  image_in[mb_byte] = image_in[mb_byte] & 8'hF7;
               end
               sdic_pkg::UNIT_TEMPERATURE: begin
                  image_in[ma_byte] = image_in[ma_byte] & ~ma;
                  image_in[mb_byte] = image_in[mb_byte] | 8'h08;
               end
               default: begin
                  image_in = image_ff;
               end
            endcase
         end
         default: begin
            image_in = image_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_ff <= '0;
      end else if (load) begin
         image_ff <= image_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff.image_low  <= image_in[7:0];
         rsp_data_ff.image_high <= image_in[10:8];
      end
   end

   assign rsp_data = rsp_data_ff;

   a_image_holds : assert property (@(posedge clock) disable iff (reset)
      !load |=> $stable(image_ff))
      else $error("image changed without a word moving to the output");

   a_rsp_matches_image : assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_data.image_low == image_ff[7:0] && rsp_data.image_high == image_ff[10:8])
      else $error("result word differs from the stored image");

   a_indicator_scope : assert property (@(posedge clock) disable iff (reset)
      load && cmd.mode == sdic_pkg::MODE_INDICATOR |=> image_ff[10:3] == $past(image_ff[10:3]))
      else $error("indicator word touched digit bytes");

   a_unit_scope : assert property (@(posedge clock) disable iff (reset)
      load && cmd.mode == sdic_pkg::MODE_UNIT |=>
         image_ff[10:7] == $past(image_ff[10:7]) && image_ff[5:3] == $past(image_ff[5:3])
         && image_ff[0] == $past(image_ff[0]))
      else $error("unit word touched bytes outside the unit segments");

   a_window1_scope : assert property (@(posedge clock) disable iff (reset)
      load && cmd.window && (cmd.mode == sdic_pkg::MODE_NUMBER || cmd.mode == sdic_pkg::MODE_CHARS)
      |=> image_ff[10:7] == $past(image_ff[10:7]) && image_ff[1:0] == $past(image_ff[1:0]))
      else $error("window 1 digits spilled outside their bytes");

endmodule

// File: hw/rtl/segment_display_image_composer.sv
// Top level of the segment display image composer: handshake control and digit lanes.
`timescale 1ns / 1ps

// Keeps the 11-byte image of a segment LCD. Each request word (a signed number or four
// characters for one window, the mode indicator bits, or a unit symbol) updates the image,
// and one response word carrying the whole image comes back for it. The block takes one
// word per clock while the response side is ready: the front stage conditions the number,
// four digit lanes
// split it into decimal digits over two stages (each a constant-reciprocal multiply), and
// the merge stage applies blanking, places the nibbles and updates the stored image in the
// cycle that loads the output register. Empty stages close up, so a stalled response does
// not stop new words from entering until all four stages are full.

module segment_display_image_composer (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  sdic_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output sdic_pkg::rsp_type rsp_data
);

   logic s1_valid_ff;
   logic s2_valid_ff;
   logic s3_valid_ff;
   logic rsp_valid_ff;
   logic rdy1;
   logic rdy2;
   logic rdy3;
   logic rdy4;

   sdic_pkg::front_type          s1_data;
   sdic_pkg::cmd_type            s2_cmd_ff;
   sdic_pkg::cmd_type            s3_cmd_ff;
   logic [3:0][13:0]             lane_scaled;
   sdic_pkg::lane_out_type [3:0] lane_out;

   assign rdy4 = !rsp_valid_ff || rsp_ready;
   assign rdy3 = !s3_valid_ff || rdy4;
   assign rdy2 = !s2_valid_ff || rdy3;
   assign rdy1 = !s1_valid_ff || rdy2;

   assign req_ready = rdy1;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rdy1) begin
            s1_valid_ff <= req_valid;
         end
         if (rdy2) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (rdy3) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (rdy4) begin
            rsp_valid_ff <= s3_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy2) begin
         s2_cmd_ff <= s1_data.cmd;
      end
      if (rdy3) begin
         s3_cmd_ff <= s2_cmd_ff;
      end
   end

   sdic_front u_front (
      .clock    (clock),
      .load     (rdy1),
      .req_data (req_data),
      .s1_data  (s1_data)
   );

   for (genvar g = 0; g < sdic_pkg::DIGITS; g++) begin : g_lane
      // leftmost digit is the thousands place
      assign lane_scaled[g] = sdic_pkg::scaled_value(s1_data.value, 2'(sdic_pkg::DIGITS - 1 - g));

      sdic_lane u_lane (
         .clock      (clock),
         .load_scale (rdy2),
         .load_digit (rdy3),
         .scaled     (lane_scaled[g]),
         .char_code  (s1_data.chars[g]),
         .lane_out   (lane_out[g])
      );
   end

   sdic_merge u_merge (
      .clock    (clock),
      .reset    (reset),
      .load     (s3_valid_ff && rdy4),
      .cmd      (s3_cmd_ff),
      .lane_out (lane_out),
      .rsp_data (rsp_data)
   );

endmodule
